[sv/pcg_pkg.sv]
// ----------------------------------------------------------------------------
// PCG32 XSH-RR package
// Constants, request codes and the output permutation shared by the block.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int unsigned StateW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ValueW = 53;

  localparam logic [StateW-1:0] LcgMult = 64'd6364136223846793005;
  localparam logic [StateW-1:0] LcgInc  = 64'd1442695040888963407;

  localparam logic [2:0] ReqRaw     = 3'd0;
  localparam logic [2:0] ReqBounded = 3'd1;
  localparam logic [2:0] ReqUnit53  = 3'd2;
  localparam logic [2:0] ReqSeed    = 3'd3;
  localparam logic [2:0] ReqRestore = 3'd4;

  // Xorshift of the old state followed by a right rotation by its top five bits.
  function automatic logic [WordW-1:0] xsh_rr(input logic [StateW-1:0] s);
    logic [StateW-1:0] mix;
    logic [WordW-1:0]  xs;
    logic [4:0]        rot;
    logic [4:0]        lrot;
    mix  = ((s >> 18) ^ s) >> 27;
    xs   = mix[WordW-1:0];
    rot  = s[63:59];
    lrot = 5'(5'd0 - rot);
    return (xs >> rot) | (xs << lrot);
  endfunction

endpackage

[sv/pcg_adv.sv]
// ----------------------------------------------------------------------------
// PCG LCG advance unit
// Computes state * mult + inc mod 2^64 with one shared 32x32 multiplier,
// one partial product per cycle.
// ----------------------------------------------------------------------------
module pcg_adv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcg_pkg::StateW-1:0]    state_i,
  output logic                          done_o,
  output logic [pcg_pkg::StateW-1:0]    state_o
);

  logic                          busy_q;
  logic [1:0]                    cnt_q;
  logic                          done_q;
  logic [pcg_pkg::StateW-1:0]    op_q;
  logic [pcg_pkg::StateW-1:0]    acc_q;
  logic [pcg_pkg::StateW-1:0]    prod_q;
  logic [pcg_pkg::WordW-1:0]     mul_a;
  logic [pcg_pkg::WordW-1:0]     mul_b;
  logic [pcg_pkg::StateW-1:0]    prod_d;

  // Only the low product needs all 64 bits; the cross products land in the
  // upper word, and the high-by-high product falls off the top.
  always_comb begin
    unique case (cnt_q)
      2'd0: begin
        mul_a = op_q[31:0];
        mul_b = pcg_pkg::LcgMult[31:0];
      end
      2'd1: begin
        mul_a = op_q[63:32];
        mul_b = pcg_pkg::LcgMult[31:0];
      end
      default: begin
        mul_a = op_q[31:0];
        mul_b = pcg_pkg::LcgMult[63:32];
      end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      op_q <= state_i;
    end else if (busy_q) begin
      if (cnt_q != 2'd3) begin
        prod_q <= prod_d;
      end
      unique case (cnt_q)
        2'd0: ;
        2'd1: acc_q <= prod_q + pcg_pkg::LcgInc;
        default: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
      endcase
    end
  end

  assign done_o  = done_q;
  assign state_o = acc_q;

endmodule

[sv/pcg_rem.sv]
// ----------------------------------------------------------------------------
// PCG remainder unit
// Restoring 32-bit unsigned remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcg_rem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pcg_pkg::WordW-1:0]    num_i,
  input  logic [pcg_pkg::WordW-1:0]    den_i,
  output logic                         done_o,
  output logic [pcg_pkg::WordW-1:0]    rem_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [4:0]                   cnt_q;
  logic [pcg_pkg::WordW-1:0]    num_q;
  logic [pcg_pkg::WordW-1:0]    den_q;
  logic [pcg_pkg::WordW-1:0]    rem_q;
  logic [pcg_pkg::WordW:0]      trial;
  logic [pcg_pkg::WordW:0]      diff;
  logic [pcg_pkg::WordW-1:0]    rem_d;

  always_comb begin
    trial = {rem_q, num_q[pcg_pkg::WordW-1]};
    diff  = trial - {1'b0, den_q};
    // The remainder stays below the divisor, so the kept value fits 32 bits.
    rem_d = diff[pcg_pkg::WordW] ? trial[pcg_pkg::WordW-1:0] : diff[pcg_pkg::WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[sv/pcg32_xsh_rr_generator_unit.sv]
// ----------------------------------------------------------------------------
// PCG32 XSH-RR generator unit
// Serves raw, bounded, unit53, seed and restore requests on a 64-bit PCG state.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_stall_o    req_type_i, operand_value_i, bound_i
//  out      output     out_valid_o / out_stall_i  random_value_o, state_out_o,
//                                                 bound_error_o
//
// Each LCG advance runs on one shared 32x32 multiplier. A raw request takes
// one advance, unit53 and seed take two. A bounded request takes two remainder
// passes and one advance per draw, with one more advance per rejected draw.
// Restore and unused codes use neither unit. Reset clears the state to zero.
// One request is in flight at a time; a finished beat waits in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
module pcg32_xsh_rr_generator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    req_type_i,
  input  logic [pcg_pkg::StateW-1:0]    operand_value_i,
  input  logic [pcg_pkg::WordW-1:0]     bound_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pcg_pkg::ValueW-1:0]    random_value_o,
  output logic [pcg_pkg::StateW-1:0]    state_out_o,
  output logic                          bound_error_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBnd  = 3'd1;
  localparam logic [2:0] StThr  = 3'd2;
  localparam logic [2:0] StAdv  = 3'd3;
  localparam logic [2:0] StVrem = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]                   st_q, st_d;
  logic [pcg_pkg::StateW-1:0]   state_q, state_d;
  logic [2:0]                   req_q;
  logic [pcg_pkg::StateW-1:0]   opnd_q;
  logic [pcg_pkg::WordW-1:0]    bnd_q;
  logic [pcg_pkg::WordW-1:0]    thr_q, thr_d;
  logic [pcg_pkg::WordW-1:0]    draw_q;
  logic [26:0]                  hi_q, hi_d;
  logic                         phase_q, phase_d;
  logic [pcg_pkg::ValueW-1:0]   val_q, val_d;
  logic                         err_q, err_d;
  logic                         out_valid_q;
  logic [pcg_pkg::ValueW-1:0]   out_val_q;
  logic [pcg_pkg::StateW-1:0]   out_state_q;
  logic                         out_err_q;

  logic                         in_accept;
  logic                         out_free;
  logic                         adv_start;
  logic [pcg_pkg::StateW-1:0]   adv_arg;
  logic                         adv_done;
  logic [pcg_pkg::StateW-1:0]   adv_res;
  logic                         rem_start;
  logic [pcg_pkg::WordW-1:0]    rem_num;
  logic                         rem_done;
  logic [pcg_pkg::WordW-1:0]    rem_res;

  assign in_stall_o = (st_q != StIdle);
  assign in_accept  = in_valid_i && (st_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  pcg_adv u_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (adv_start),
    .state_i (adv_arg),
    .done_o  (adv_done),
    .state_o (adv_res)
  );

  pcg_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .num_i   (rem_num),
    .den_i   (bnd_q),
    .done_o  (rem_done),
    .rem_o   (rem_res)
  );

  always_comb begin
    st_d      = st_q;
    state_d   = state_q;
    thr_d     = thr_q;
    hi_d      = hi_q;
    phase_d   = phase_q;
    val_d     = val_q;
    err_d     = err_q;
    adv_start = 1'b0;
    adv_arg   = state_q;
    rem_start = 1'b0;
    rem_num   = draw_q;

    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          val_d   = '0;
          err_d   = 1'b0;
          phase_d = 1'b0;
          unique case (req_type_i)
            pcg_pkg::ReqRaw, pcg_pkg::ReqUnit53: begin
              adv_start = 1'b1;
              st_d      = StAdv;
            end
            pcg_pkg::ReqSeed: begin
              adv_start = 1'b1;
              adv_arg   = '0;
              st_d      = StAdv;
            end
            pcg_pkg::ReqBounded: begin
              if (bound_i == '0) begin
                err_d = 1'b1;
                st_d  = StDone;
              end else begin
                st_d = StBnd;
              end
            end
            pcg_pkg::ReqRestore: begin
              state_d = operand_value_i;
              st_d    = StDone;
            end
            default: st_d = StDone;
          endcase
        end
      end
      StBnd: begin
        // Rejection threshold is (2^32 - bound) mod bound.
        rem_start = 1'b1;
        rem_num   = (~bnd_q) + 32'd1;
        st_d      = StThr;
      end
      StThr: begin
        if (rem_done) begin
          thr_d     = rem_res;
          adv_start = 1'b1;
          st_d      = StAdv;
        end
      end
      StAdv: begin
        if (adv_done) begin
          state_d = adv_res;
          adv_arg = adv_res;
          unique case (req_q)
            pcg_pkg::ReqRaw: begin
              val_d = 53'(draw_q);
              st_d  = StDone;
            end
            pcg_pkg::ReqBounded: begin
              if (draw_q >= thr_q) begin
                rem_start = 1'b1;
                st_d      = StVrem;
              end else begin
                adv_start = 1'b1;
              end
            end
            pcg_pkg::ReqUnit53: begin
              if (!phase_q) begin
                hi_d      = draw_q[31:5];
                phase_d   = 1'b1;
                adv_start = 1'b1;
              end else begin
                val_d = {hi_q, draw_q[31:6]};
                st_d  = StDone;
              end
            end
            default: begin
              // Seed: second advance starts from the first result plus the seed.
              if (!phase_q) begin
                phase_d   = 1'b1;
                adv_arg   = adv_res + opnd_q;
                adv_start = 1'b1;
              end else begin
                st_d = StDone;
              end
            end
          endcase
        end
      end
      StVrem: begin
        if (rem_done) begin
          val_d = 53'(rem_res);
          st_d  = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      state_q <= state_d;
      if (st_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q   <= thr_d;
    hi_q    <= hi_d;
    phase_q <= phase_d;
    val_q   <= val_d;
    err_q   <= err_d;
    if (in_accept) begin
      req_q  <= req_type_i;
      opnd_q <= operand_value_i;
      bnd_q  <= bound_i;
    end
    if (adv_start) begin
      draw_q <= pcg_pkg::xsh_rr(adv_arg);
    end
    if (st_q == StDone && out_free) begin
      out_val_q   <= val_q;
      out_state_q <= state_q;
      out_err_q   <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_val_q;
  assign state_out_o    = out_state_q;
  assign bound_error_o  = out_err_q;

endmodule
